>>> rtl/mbrtu_pkg.sv
// ---------------------------------------------------------------------------
// mbrtu_pkg
// Shared types, constants and the crc byte step of the modbus rtu slave.
// ---------------------------------------------------------------------------
package mbrtu_pkg;

	localparam int RX_DEPTH    = 256;
	localparam int RX_AW       = $clog2(RX_DEPTH);
	localparam int COIL_COUNT  = 6;
	localparam int INPUT_COUNT = 4;
	localparam int HOLD_COUNT  = 4;
	localparam int HDR_BYTES   = 15;
	localparam int TX_MAX      = 13;

	localparam logic [15:0] COIL_ON  = 16'hFF00;
	localparam logic [15:0] CRC_INIT = 16'hFFFF;
	localparam logic [15:0] CRC_POLY = 16'hA001;

	localparam logic [7:0] FC_RD_COILS = 8'd1;
	localparam logic [7:0] FC_RD_DISC  = 8'd2;
	localparam logic [7:0] FC_RD_HOLD  = 8'd3;
	localparam logic [7:0] FC_RD_INPUT = 8'd4;
	localparam logic [7:0] FC_WR_COIL  = 8'd5;
	localparam logic [7:0] FC_WR_REG   = 8'd6;
	localparam logic [7:0] FC_WR_COILS = 8'd15;
	localparam logic [7:0] FC_WR_REGS  = 8'd16;

	localparam logic CFG_DEVICE_ID = 1'b0;
	localparam logic CFG_TIMEOUT   = 1'b1;

	typedef enum logic [4:0] {
		ST_IDLE  = 5'b00001,
		ST_SCAN  = 5'b00010,
		ST_BUILD = 5'b00100,
		ST_TXCRC = 5'b01000,
		ST_SEND  = 5'b10000
	} state_t;

	typedef logic [7:0] byte_t;

	// one byte through the crc-16/modbus shift register, eight bit steps
	function automatic logic [15:0] crc_byte(input logic [15:0] c, input byte_t d);
		logic [15:0] r;
		r = c ^ {8'h00, d};
		for (int b = 0; b < 8; b++) begin
			if (r[0]) begin
				r = (r >> 1) ^ CRC_POLY;
			end else begin
				r = r >> 1;
			end
		end
		return r;
	endfunction

endpackage

>>> rtl/mbrtu_ram.sv
// ---------------------------------------------------------------------------
// mbrtu_ram
// Generic single-port-write, registered-read RAM.
// ---------------------------------------------------------------------------
module mbrtu_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

>>> rtl/modbus_rtu_slave_top.sv
// ---------------------------------------------------------------------------
// modbus_rtu_slave_top
// Modbus rtu slave: frame store, frame check, request service, reply out.
// ---------------------------------------------------------------------------
// Input transactions carry either a received byte (s_tuser = 0) or one timer
// tick (s_tuser = 1), together with the live discrete inputs and converter
// values. A byte is written into a 256 x 8 frame RAM. A tick that pushes
// the silence count past timeout_ticks closes the frame: the RAM is scanned
// one byte a cycle through its single read port, with the crc unit stepping
// over each byte ahead of the received crc, then the reply is built in
// ST_BUILD, its crc is stepped over each body byte in ST_TXCRC, and the
// bytes leave on the m_ channel one per transaction, tlast on the final one.
// s_tready stays low from the closing tick until the last reply byte has
// been taken, or a build gives no reply; a stalled receiver simply holds the
// block there. The cfg channel is always ready (index 0 device_id,
// 1 timeout_ticks). Reset clears coils, holding registers and frame state;
// device_id goes to 1 and timeout_ticks to 2. The frame RAM is not cleared.
// ---------------------------------------------------------------------------
module modbus_rtu_slave_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [63:0] s_tdata,  // rx_byte, discrete_in, adc_ch0..adc_ch3, zero pad
	input  logic        s_tuser,  // mode
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [79:0] m_tdata,  // tx_byte, coil_bits, hold_reg0..hold_reg3, zero pad
	output logic        m_tlast,  // tx_last
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_index,
	input  logic [7:0]  cfg_data
);

	mbrtu_pkg::state_t state_q;

	logic [7:0]  dev_id_q, timeout_q;
	logic [8:0]  len_q, sil_q, iss_q;
	logic        recv_q;
	logic        rv_s1;
	logic [8:0]  ridx_s1;
	logic [15:0] crc_q;
	logic [15:0] crc_rx_q;
	mbrtu_pkg::byte_t hdr_q [mbrtu_pkg::HDR_BYTES];
	logic [3:0]  din_q;
	logic [11:0] adc_q [4];
	logic [mbrtu_pkg::COIL_COUNT-1:0] coil_q;
	logic [15:0] hold_q [mbrtu_pkg::HOLD_COUNT];
	mbrtu_pkg::byte_t txb_q [mbrtu_pkg::TX_MAX];
	logic [3:0]  nb_q, tix_q;
	logic        m_tvalid_q, m_tlast_q;
	logic [7:0]  m_byte_q;

	logic        s_acc;
	logic [8:0]  wlen;
	logic        ram_we;
	mbrtu_pkg::byte_t ram_rdata;
	logic [8:0]  nscan;

	assign s_acc     = s_tvalid && s_tready;
	assign s_tready  = (state_q == mbrtu_pkg::ST_IDLE);
	assign cfg_ready = 1'b1;
	assign wlen      = (len_q >= 9'(mbrtu_pkg::RX_DEPTH)) ? 9'd0 : len_q;
	assign ram_we    = s_acc && !s_tuser;
	assign nscan     = (len_q > 9'(mbrtu_pkg::HDR_BYTES)) ? len_q : 9'(mbrtu_pkg::HDR_BYTES);

	mbrtu_ram #(.WIDTH(8), .DEPTH(mbrtu_pkg::RX_DEPTH)) u_frame_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (wlen[mbrtu_pkg::RX_AW-1:0]),
		.wdata (s_tdata[7:0]),
		.raddr (iss_q[mbrtu_pkg::RX_AW-1:0]),
		.rdata (ram_rdata)
	);

	// reply build and write-back, decided combinationally from the captured header
	logic [15:0] addr, cnt;
	logic [16:0] sum;
	logic        frame_ok;
	logic [7:0]  fc;
	logic        reply;
	logic [3:0]  nb_d;
	mbrtu_pkg::byte_t buf_d [mbrtu_pkg::TX_MAX];
	logic [mbrtu_pkg::COIL_COUNT-1:0] coil_d;
	logic [15:0] hold_d [mbrtu_pkg::HOLD_COUNT];

	always_comb begin
		logic [15:0] src;
		logic [7:0]  acc;
		logic [15:0] v;
		logic [3:0]  bi;
		logic [1:0]  ri;
		logic [16:0] lim;
		addr     = {hdr_q[2], hdr_q[3]};
		cnt      = {hdr_q[4], hdr_q[5]};
		sum      = {1'b0, addr} + {1'b0, cnt};
		fc       = hdr_q[1];
		frame_ok = (len_q > 9'd4) && (hdr_q[0] == dev_id_q) && (crc_q == crc_rx_q);
		reply    = 1'b0;
		nb_d     = 4'd6;
		coil_d   = coil_q;
		for (int h = 0; h < mbrtu_pkg::HOLD_COUNT; h++) hold_d[h] = hold_q[h];
		for (int k = 0; k < mbrtu_pkg::TX_MAX; k++) buf_d[k] = 8'h00;
		for (int k = 0; k < 6; k++) buf_d[k] = hdr_q[k];
		src = 16'h0000;
		acc = 8'h00;
		v   = 16'h0000;
		bi  = 4'd0;
		ri  = 2'd0;
		lim = 17'd0;
		if (frame_ok) begin
			case (fc)
				mbrtu_pkg::FC_RD_COILS, mbrtu_pkg::FC_RD_DISC: begin
					if (fc == mbrtu_pkg::FC_RD_COILS) begin
						lim = 17'(mbrtu_pkg::COIL_COUNT);
						src = 16'(coil_q);
					end else begin
						lim = 17'(mbrtu_pkg::INPUT_COUNT);
						src = {12'h000, din_q};
					end
					if (sum <= lim) begin
						reply = 1'b1;
						for (int j = 0; j < 8; j++) begin
							bi = addr[3:0] + 4'(j);
							if (16'(j) < cnt) acc[j] = src[bi];
						end
						buf_d[2] = (cnt != 16'd0) ? 8'd1 : 8'd0;
						buf_d[3] = acc;
						nb_d = (cnt != 16'd0) ? 4'd4 : 4'd3;
					end
				end
				mbrtu_pkg::FC_RD_HOLD, mbrtu_pkg::FC_RD_INPUT: begin
					lim = (fc == mbrtu_pkg::FC_RD_HOLD) ? 17'(mbrtu_pkg::HOLD_COUNT)
						: 17'(mbrtu_pkg::INPUT_COUNT);
					if (sum <= lim) begin
						reply = 1'b1;
						buf_d[2] = {cnt[6:0], 1'b0};
						for (int j = 0; j < 4; j++) begin
							ri = addr[1:0] + 2'(j);
							v = (fc == mbrtu_pkg::FC_RD_HOLD) ? hold_q[ri] : {4'h0, adc_q[ri]};
							if (16'(j) < cnt) begin
								buf_d[3 + 2*j] = v[15:8];
								buf_d[4 + 2*j] = v[7:0];
							end
						end
						nb_d = 4'd3 + {cnt[2:0], 1'b0};
					end
				end
				mbrtu_pkg::FC_WR_COIL: begin
					if (addr < 16'(mbrtu_pkg::COIL_COUNT)) begin
						reply = 1'b1;
						coil_d[addr[2:0]] = (cnt == mbrtu_pkg::COIL_ON);
					end
				end
				mbrtu_pkg::FC_WR_REG: begin
					if (addr < 16'(mbrtu_pkg::HOLD_COUNT)) begin
						reply = 1'b1;
						hold_d[addr[1:0]] = cnt;
					end
				end
				mbrtu_pkg::FC_WR_COILS: begin
					if (sum <= 17'(mbrtu_pkg::COIL_COUNT)) begin
						reply = 1'b1;
						for (int j = 0; j < mbrtu_pkg::COIL_COUNT; j++) begin
							bi = 4'(j) - addr[3:0];
							if (16'(j) >= addr && 17'(j) < sum) coil_d[j] = hdr_q[7][bi[2:0]];
						end
					end
				end
				mbrtu_pkg::FC_WR_REGS: begin
					if (sum <= 17'(mbrtu_pkg::HOLD_COUNT)) begin
						reply = 1'b1;
						for (int j = 0; j < mbrtu_pkg::HOLD_COUNT; j++) begin
							ri = 2'(j) - addr[1:0];
							if (16'(j) >= addr && 17'(j) < sum)
								hold_d[j] = {hdr_q[7 + 2*ri], hdr_q[8 + 2*ri]};
						end
					end
				end
				default: reply = 1'b0;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= mbrtu_pkg::ST_IDLE;
			dev_id_q   <= 8'd1;
			timeout_q  <= 8'd2;
			len_q      <= '0;
			sil_q      <= '0;
			recv_q     <= 1'b0;
			iss_q      <= '0;
			rv_s1      <= 1'b0;
			coil_q     <= '0;
			for (int h = 0; h < mbrtu_pkg::HOLD_COUNT; h++) hold_q[h] <= '0;
			nb_q       <= '0;
			tix_q      <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					mbrtu_pkg::CFG_DEVICE_ID: dev_id_q  <= cfg_data;
					mbrtu_pkg::CFG_TIMEOUT:   timeout_q <= cfg_data;
					default: ;
				endcase
			end
			case (state_q)
				mbrtu_pkg::ST_IDLE: begin
					if (s_acc) begin
						din_q <= s_tdata[11:8];
						for (int a = 0; a < 4; a++) adc_q[a] <= s_tdata[12 + 12*a +: 12];
						if (!s_tuser) begin
							len_q  <= wlen + 9'd1;
							sil_q  <= '0;
							recv_q <= 1'b1;
						end else if (recv_q) begin
							if (sil_q + 9'd1 > {1'b0, timeout_q}) begin
								sil_q   <= '0;
								recv_q  <= 1'b0;
								iss_q   <= '0;
								rv_s1   <= 1'b0;
								crc_q   <= mbrtu_pkg::CRC_INIT;
								state_q <= mbrtu_pkg::ST_SCAN;
							end else begin
								sil_q <= sil_q + 9'd1;
							end
						end
					end
				end
				mbrtu_pkg::ST_SCAN: begin
					rv_s1   <= (iss_q < nscan);
					ridx_s1 <= iss_q;
					if (iss_q < nscan) iss_q <= iss_q + 9'd1;
					if (rv_s1) begin
						if (ridx_s1 < len_q - 9'd2) crc_q <= mbrtu_pkg::crc_byte(crc_q, ram_rdata);
						if (ridx_s1 == len_q - 9'd2) crc_rx_q[7:0]  <= ram_rdata;
						if (ridx_s1 == len_q - 9'd1) crc_rx_q[15:8] <= ram_rdata;
						if (ridx_s1 < 9'(mbrtu_pkg::HDR_BYTES)) hdr_q[ridx_s1[3:0]] <= ram_rdata;
					end
					if (iss_q == nscan && !rv_s1) state_q <= mbrtu_pkg::ST_BUILD;
				end
				mbrtu_pkg::ST_BUILD: begin
					len_q  <= '0;
					coil_q <= coil_d;
					for (int h = 0; h < mbrtu_pkg::HOLD_COUNT; h++) hold_q[h] <= hold_d[h];
					for (int k = 0; k < mbrtu_pkg::TX_MAX; k++) txb_q[k] <= buf_d[k];
					nb_q    <= nb_d;
					tix_q   <= '0;
					crc_q   <= mbrtu_pkg::CRC_INIT;
					state_q <= reply ? mbrtu_pkg::ST_TXCRC : mbrtu_pkg::ST_IDLE;
				end
				mbrtu_pkg::ST_TXCRC: begin
					if (tix_q < nb_q) begin
						crc_q <= mbrtu_pkg::crc_byte(crc_q, txb_q[tix_q]);
						tix_q <= tix_q + 4'd1;
					end else begin
						txb_q[nb_q]        <= crc_q[7:0];
						txb_q[nb_q + 4'd1] <= crc_q[15:8];
						nb_q    <= nb_q + 4'd2;
						tix_q   <= '0;
						state_q <= mbrtu_pkg::ST_SEND;
					end
				end
				mbrtu_pkg::ST_SEND: begin
					if (!m_tvalid_q || m_tready) begin
						if (tix_q < nb_q) begin
							m_tvalid_q <= 1'b1;
							m_byte_q   <= txb_q[tix_q];
							m_tlast_q  <= (tix_q + 4'd1 == nb_q);
							tix_q      <= tix_q + 4'd1;
						end else begin
							m_tvalid_q <= 1'b0;
							state_q    <= mbrtu_pkg::ST_IDLE;
						end
					end
				end
				default: state_q <= mbrtu_pkg::ST_IDLE;
			endcase
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tlast  = m_tlast_q;
	assign m_tdata  = {2'b00, hold_q[3], hold_q[2], hold_q[1], hold_q[0], coil_q, m_byte_q};

endmodule

>>> sim/modbus_rtu_slave_top_tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// modbus_rtu_slave_top_tb
// Regression of the modbus rtu slave: request frames and ticks are streamed
// in, every reply byte is checked against a behavioural slave model.
// ---------------------------------------------------------------------------
module modbus_rtu_slave_top_tb;

	typedef struct packed {
		logic [7:0]  txb;
		logic        last;
		logic [5:0]  coils;
		logic [15:0] h0, h1, h2, h3;
	} reply_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [63:0] s_tdata = '0;
	logic        s_tuser = 1'b0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [79:0] m_tdata;
	logic        m_tlast;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic        cfg_index = 1'b0;
	logic [7:0]  cfg_data = '0;

	modbus_rtu_slave_top u_dut (.*);

	initial forever #1 clk = ~clk;

	// model state
	logic [7:0]  rx_buf [mbrtu_pkg::RX_DEPTH];
	int unsigned rx_len, quiet;
	logic        in_frame;
	logic [5:0]  coil_q;
	logic [15:0] hold_q [mbrtu_pkg::HOLD_COUNT];
	logic [7:0]  my_id, tmo;
	reply_t      reply_q [$];
	mbrtu_pkg::byte_t txbuf [$];
	int          errors = 0;
	bit          rx_calm = 0;
	bit          tx_calm = 0;
	int          idle_cnt = 0;

	function automatic logic [15:0] crc_of(input mbrtu_pkg::byte_t b [$]);
		logic [15:0] c;
		c = 16'hFFFF;
		foreach (b[i]) begin
			c = c ^ {8'h00, b[i]};
			for (int k = 0; k < 8; k++) c = c[0] ? ((c >> 1) ^ 16'hA001) : (c >> 1);
		end
		return c;
	endfunction

	function automatic mbrtu_pkg::byte_t rd(input int unsigned i);
		return (i < mbrtu_pkg::RX_DEPTH) ? rx_buf[i] : 8'h00;
	endfunction

	function automatic void seal();
		logic [15:0] c;
		c = crc_of(txbuf);
		txbuf.push_back(c[7:0]);
		txbuf.push_back(c[15:8]);
	endfunction

	function automatic void echo_head();
		txbuf.delete();
		for (int i = 0; i < 6; i++) txbuf.push_back(rd(i));
		seal();
	endfunction

	function automatic void serve_frame(input logic [3:0] din, input logic [11:0] adc [4]);
		mbrtu_pkg::byte_t body [$];
		logic [15:0] c, v;
		logic [7:0]  fc;
		logic [7:0]  acc [2];
		int unsigned addr, cnt, lim, nb;
		logic [15:0] src;
		mbrtu_pkg::byte_t bt;
		txbuf.delete();
		if (rx_len <= 4 || rd(0) != my_id) return;
		for (int i = 0; i < rx_len - 2; i++) body.push_back(rx_buf[i]);
		c = crc_of(body);
		if (c[7:0] != rd(rx_len - 2) || c[15:8] != rd(rx_len - 1)) return;
		fc = rd(1);
		addr = 32'({rd(2), rd(3)});
		cnt = 32'({rd(4), rd(5)});
		case (fc)
			mbrtu_pkg::FC_RD_COILS, mbrtu_pkg::FC_RD_DISC: begin
				lim = (fc == mbrtu_pkg::FC_RD_COILS) ? mbrtu_pkg::COIL_COUNT
					: mbrtu_pkg::INPUT_COUNT;
				src = (fc == mbrtu_pkg::FC_RD_COILS) ? {10'd0, coil_q} : {12'd0, din};
				if (addr + cnt > lim) return;
				nb = (cnt + 7) >> 3;
				acc[0] = 8'h00;
				acc[1] = 8'h00;
				for (int i = 0; i < cnt; i++)
					if (src[addr + i]) acc[(i >> 3) & 1][i & 7] = 1'b1;
				txbuf.push_back(rd(0));
				txbuf.push_back(fc);
				txbuf.push_back(nb[7:0]);
				for (int i = 0; i < nb && i < 2; i++) txbuf.push_back(acc[i]);
				seal();
			end
			mbrtu_pkg::FC_RD_HOLD, mbrtu_pkg::FC_RD_INPUT: begin
				lim = (fc == mbrtu_pkg::FC_RD_HOLD) ? mbrtu_pkg::HOLD_COUNT
					: mbrtu_pkg::INPUT_COUNT;
				if (addr + cnt > lim) return;
				txbuf.push_back(rd(0));
				txbuf.push_back(fc);
				txbuf.push_back(8'(cnt << 1));
				for (int i = 0; i < cnt; i++) begin
					v = (fc == mbrtu_pkg::FC_RD_HOLD) ? hold_q[addr + i] : {4'd0, adc[addr + i]};
					txbuf.push_back(v[15:8]);
					txbuf.push_back(v[7:0]);
				end
				seal();
			end
			mbrtu_pkg::FC_WR_COIL: begin
				if (addr >= mbrtu_pkg::COIL_COUNT) return;
				coil_q[addr] = (cnt[15:0] == mbrtu_pkg::COIL_ON);
				echo_head();
			end
			mbrtu_pkg::FC_WR_REG: begin
				if (addr >= mbrtu_pkg::HOLD_COUNT) return;
				hold_q[addr] = cnt[15:0];
				echo_head();
			end
			mbrtu_pkg::FC_WR_COILS: begin
				if (addr + cnt > mbrtu_pkg::COIL_COUNT) return;
				for (int i = 0; i < cnt; i++) begin
					bt = rd(7 + (i >> 3));
					coil_q[addr + i] = bt[i & 7];
				end
				echo_head();
			end
			mbrtu_pkg::FC_WR_REGS: begin
				if (addr + cnt > mbrtu_pkg::HOLD_COUNT) return;
				for (int i = 0; i < cnt; i++) hold_q[addr + i] = {rd(7 + 2 * i), rd(8 + 2 * i)};
				echo_head();
			end
			default: ;
		endcase
	endfunction

	// advances the model by one input transaction, queues reply bytes
	function automatic void predict_reply(input logic mode, input logic [63:0] d);
		logic [11:0] adc [4];
		reply_t      r;
		for (int i = 0; i < 4; i++) adc[i] = d[12 + 12 * i +: 12];
		txbuf.delete();
		if (!mode) begin
			if (rx_len >= mbrtu_pkg::RX_DEPTH) rx_len = 0;
			rx_buf[rx_len] = d[7:0];
			rx_len++;
			quiet = 0;
			in_frame = 1'b1;
		end else if (in_frame) begin
			quiet++;
			if (quiet > tmo) begin
				serve_frame(d[11:8], adc);
				rx_len = 0;
				quiet = 0;
				in_frame = 1'b0;
			end
		end
		foreach (txbuf[k]) begin
			r = '{txbuf[k], k == txbuf.size() - 1, coil_q, hold_q[0], hold_q[1],
				hold_q[2], hold_q[3]};
			reply_q.push_back(r);
		end
	endfunction

	task automatic send_item(input logic mode, input logic [7:0] b);
		logic [63:0] d;
		d = {$urandom, $urandom};
		d[63:60] = 4'd0;
		d[7:0] = b;
		while (!rx_calm && $urandom_range(99) < 27) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= mode;
		s_tdata <= d;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		predict_reply(mode, d);
	endtask

	task automatic drain();
		int n;
		n = 0;
		s_tvalid <= 1'b0;
		while ((reply_q.size() != 0 || !s_tready) && n < 200000) begin
			@(posedge clk);
			n++;
		end
		repeat (40) @(posedge clk);
	endtask

	task automatic write_cfg(input logic idx, input logic [7:0] v);
		drain();
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= v;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		if (idx == mbrtu_pkg::CFG_DEVICE_ID) my_id = v;
		else tmo = v;
	endtask

	task automatic send_frame(input mbrtu_pkg::byte_t f [$], input bit good_crc);
		logic [15:0] c;
		c = crc_of(f);
		if (!good_crc) c ^= 16'h0001 << $urandom_range(15);
		foreach (f[i]) send_item(1'b0, f[i]);
		send_item(1'b0, c[7:0]);
		send_item(1'b0, c[15:8]);
	endtask

	task automatic close_frame();
		for (int i = 0; i <= tmo; i++) send_item(1'b1, 8'($urandom));
	endtask

	task automatic request(input mbrtu_pkg::byte_t f [$]);
		send_frame(f, 1'b1);
		close_frame();
	endtask

	task automatic test_directed();
		request('{my_id, mbrtu_pkg::FC_RD_COILS, 8'd0, 8'd0, 8'd0, 8'd6});
		request('{my_id, mbrtu_pkg::FC_WR_COIL, 8'd0, 8'd5, 8'hFF, 8'h00});
		request('{my_id, mbrtu_pkg::FC_WR_COILS, 8'd0, 8'd0, 8'd0, 8'd6, 8'd1, 8'h2A});
		request('{my_id, mbrtu_pkg::FC_RD_COILS, 8'd0, 8'd1, 8'd0, 8'd5});
		request('{my_id, mbrtu_pkg::FC_RD_DISC, 8'd0, 8'd0, 8'd0, 8'd4});
		request('{my_id, mbrtu_pkg::FC_WR_REG, 8'd0, 8'd3, 8'hFF, 8'hFF});
		request('{my_id, mbrtu_pkg::FC_WR_REGS, 8'd0, 8'd0, 8'd0, 8'd2, 8'd4, 8'h12, 8'h34,
			8'h00, 8'h00});
		request('{my_id, mbrtu_pkg::FC_RD_HOLD, 8'd0, 8'd0, 8'd0, 8'd4});
		request('{my_id, mbrtu_pkg::FC_RD_INPUT, 8'd0, 8'd0, 8'd0, 8'd4});
		request('{my_id, mbrtu_pkg::FC_RD_INPUT, 8'd0, 8'd2, 8'd0, 8'd0});
		// past a table, unknown code, wrong address, short, bad crc
		request('{my_id, mbrtu_pkg::FC_RD_HOLD, 8'd0, 8'd3, 8'd0, 8'd2});
		request('{my_id, mbrtu_pkg::FC_WR_COIL, 8'd0, 8'd6, 8'hFF, 8'h00});
		request('{my_id, 8'h07, 8'd0, 8'd0, 8'd0, 8'd1});
		request('{8'(my_id + 1), mbrtu_pkg::FC_RD_HOLD, 8'd0, 8'd0, 8'd0, 8'd1});
		request('{my_id, mbrtu_pkg::FC_RD_HOLD});
		send_frame('{my_id, mbrtu_pkg::FC_RD_HOLD, 8'd0, 8'd0, 8'd0, 8'd1}, 1'b0);
		close_frame();
		// tick while idle
		send_item(1'b1, 8'h00);
		// short write-many frame reads stale bytes beyond the length
		request('{my_id, mbrtu_pkg::FC_WR_REGS, 8'd0, 8'd0, 8'd0, 8'd1});
		drain();
	endtask

	task automatic test_config();
		write_cfg(mbrtu_pkg::CFG_DEVICE_ID, 8'd255);
		write_cfg(mbrtu_pkg::CFG_TIMEOUT, 8'd0);
		request('{my_id, mbrtu_pkg::FC_RD_HOLD, 8'd0, 8'd0, 8'd0, 8'd4});
		request('{8'd1, mbrtu_pkg::FC_RD_HOLD, 8'd0, 8'd0, 8'd0, 8'd1});
		write_cfg(mbrtu_pkg::CFG_DEVICE_ID, 8'd0);
		write_cfg(mbrtu_pkg::CFG_TIMEOUT, 8'd1);
		request('{my_id, mbrtu_pkg::FC_WR_REG, 8'd0, 8'd1, 8'h5A, 8'hA5});
		drain();
	endtask

	task automatic random_request();
		mbrtu_pkg::byte_t f [$];
		int    fcs [8] = '{1, 2, 3, 4, 5, 6, 15, 16};
		logic [7:0] fc;
		int cnt;
		fc = 8'(fcs[$urandom_range(7)]);
		cnt = $urandom_range(4);
		f = '{my_id, fc, 8'd0, 8'($urandom_range(5)), 8'd0, 8'(cnt)};
		if ($urandom_range(9) == 0) f[2] = 8'($urandom);
		if (fc == mbrtu_pkg::FC_WR_COIL || fc == mbrtu_pkg::FC_WR_REG) begin
			f[4] = $urandom_range(1) ? 8'hFF : 8'($urandom);
			f[5] = $urandom_range(1) ? 8'h00 : 8'($urandom);
		end
		if (fc == mbrtu_pkg::FC_WR_COILS || fc == mbrtu_pkg::FC_WR_REGS) begin
			f.push_back(8'(2 * cnt));
			for (int i = 0; i < 2 * cnt; i++) f.push_back(8'($urandom));
		end
		if ($urandom_range(9) == 0) f[0] = 8'($urandom);
		if ($urandom_range(14) == 0) f[1] = 8'($urandom);
		send_frame(f, $urandom_range(11) != 0);
		close_frame();
	endtask

	task automatic test_random(input int items);
		int sent;
		sent = 0;
		while (sent < items) begin
			if ($urandom_range(9) == 0) begin
				send_item(1'($urandom_range(1)), 8'($urandom));
				sent++;
			end else begin
				random_request();
				sent += 10;
			end
		end
	endtask

	// reply checker
	always @(posedge clk) begin
		reply_t got, want;
		if (m_tvalid && m_tready) begin
			got = '{m_tdata[7:0], m_tlast, m_tdata[13:8], m_tdata[29:14], m_tdata[45:30],
				m_tdata[61:46], m_tdata[77:62]};
			if (reply_q.size() == 0) begin
				$display("%0t: unexpected reply byte, expected none actual %h", $time, got);
				errors++;
			end else begin
				want = reply_q.pop_front();
				if (got.txb !== want.txb)
					$display("%0t: tx_byte expected %h actual %h", $time, want.txb, got.txb);
				if (got.last !== want.last)
					$display("%0t: tx_last expected %b actual %b", $time, want.last, got.last);
				if (got.coils !== want.coils)
					$display("%0t: coil_bits expected %h actual %h", $time, want.coils, got.coils);
				if ({got.h0, got.h1, got.h2, got.h3} !== {want.h0, want.h1, want.h2, want.h3})
					$display("%0t: hold_regs expected %h actual %h", $time,
						{want.h0, want.h1, want.h2, want.h3}, {got.h0, got.h1, got.h2, got.h3});
				if (got !== want) errors++;
			end
		end
	end

	// receiver stalls
	always @(posedge clk) m_tready <= tx_calm || ($urandom_range(99) >= 27);

	// watchdog on cycles without a transaction
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
			idle_cnt <= 0;
		else
			idle_cnt <= idle_cnt + 1;
		if (idle_cnt > 20000) begin
			$display("modbus_rtu_slave_top regression: fail");
			$finish;
		end
	end

	initial begin
		rx_len = 0;
		quiet = 0;
		in_frame = 1'b0;
		coil_q = '0;
		for (int i = 0; i < mbrtu_pkg::HOLD_COUNT; i++) hold_q[i] = '0;
		for (int i = 0; i < mbrtu_pkg::RX_DEPTH; i++) rx_buf[i] = '0;
		my_id = 8'd1;
		tmo = 8'd2;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		// fill the header area so no unwritten entry is ever read
		for (int i = 0; i < 16; i++) send_item(1'b0, 8'($urandom));
		close_frame();
		test_directed();
		test_config();
		write_cfg(mbrtu_pkg::CFG_DEVICE_ID, 8'($urandom_range(1, 254)));
		rx_calm = 1;
		tx_calm = 1;
		test_random(25);
		rx_calm = 0;
		tx_calm = 0;
		drain();
		test_random(25);
		drain();
		if (errors == 0 && reply_q.size() == 0) begin
			$display("modbus_rtu_slave_top regression: pass");
		end else begin
			$display("modbus_rtu_slave_top regression: fail");
		end
		$finish;
	end

endmodule

>>> filelist.f
rtl/mbrtu_pkg.sv
rtl/mbrtu_ram.sv
rtl/modbus_rtu_slave_top.sv
sim/modbus_rtu_slave_top_tb.sv
